// ===== rtl/gha_pkg.sv =====
`timescale 1ns / 1ps

package gha_pkg;

	// default sizes
	localparam int DEF_SLOT_BITS = 10;
	localparam int DEF_GEN_BITS  = 16;
	localparam int DEF_AUX_SLOTS = 256;
	localparam int DEF_KIND_BITS = 16;

	// request command codes as seen on the port
	localparam logic [1:0] CMD_ALLOC  = 2'd0;
	localparam logic [1:0] CMD_FREE   = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	// response status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_STALE    = 3'd2;
	localparam logic [2:0] ST_AUX_EXH  = 3'd3;
	localparam logic [2:0] ST_AUX_IDLE = 3'd4;

	// decoded operation
	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_FREE,
		OP_LOOKUP,
		OP_BAD
	} op_t;

	// control word carried from front to back
	typedef struct packed {
		op_t  op;
		logic wants_aux;
	} ctl_t;

endpackage

// ===== rtl/generational_handle_allocator.sv =====
`timescale 1ns / 1ps
// a request waits in the front queue until the back end sequencer pops it in idle; a full
//   table answers from idle, lookup and free go through the check state, alloc through
//   the alloc state, an aux free adds the free aux state, an aux grant aux first and maybe
//   aux next; new requests wait for idle and the registered occupancy and aux row reads
// reset: asynchronous active low; all slots free, all aux slots free, generation and
//   rotating aux pointer zero; no clearing pass, row valid bits mask unwritten memory

module generational_handle_allocator #(
	parameter int SLOT_BITS = gha_pkg::DEF_SLOT_BITS,
	parameter int GEN_BITS  = gha_pkg::DEF_GEN_BITS,
	parameter int AUX_SLOTS = gha_pkg::DEF_AUX_SLOTS,
	parameter int KIND_BITS = gha_pkg::DEF_KIND_BITS,
	localparam int HW    = GEN_BITS + SLOT_BITS,
	localparam int AUX_W = $clog2(AUX_SLOTS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [1:0]           cmd,
	input  logic [HW-1:0]        handle,
	input  logic [KIND_BITS-1:0] kind,
	input  logic                 wants_aux,
	// response channel
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [2:0]           status,
	output logic [HW-1:0]        handle_out,
	output logic [KIND_BITS-1:0] kind_out,
	output logic [AUX_W-1:0]     aux_slot
);
	import gha_pkg::*;

	// front to back queue head
	logic                 q_valid;
	logic                 q_pop;
	ctl_t                 q_ctl;
	logic [HW-1:0]        q_handle;
	logic [KIND_BITS-1:0] q_kind;

	// front: takes each transfer, decodes the command and parks it in a
	// two entry queue; the requester only waits once both entries are taken
	gha_front #(
		.HW        (HW),
		.KIND_BITS (KIND_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.handle    (handle),
		.kind      (kind),
		.wants_aux (wants_aux),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_ctl     (q_ctl),
		.q_handle  (q_handle),
		.q_kind    (q_kind)
	);

	// back: slot table, two level occupancy bitmaps, rotating aux allocator
	// and the response register; pops the queue only when the response
	// register will be free by the time the result is ready
	gha_back #(
		.SLOT_BITS (SLOT_BITS),
		.GEN_BITS  (GEN_BITS),
		.AUX_SLOTS (AUX_SLOTS),
		.KIND_BITS (KIND_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_ctl      (q_ctl),
		.q_handle   (q_handle),
		.q_kind     (q_kind),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.handle_out (handle_out),
		.kind_out   (kind_out),
		.aux_slot   (aux_slot)
	);

endmodule

// ===== rtl/gha_front.sv =====
`timescale 1ns / 1ps

module gha_front #(
	parameter int HW = 26,
	parameter int KIND_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [1:0]          cmd,
	input  logic [HW-1:0]       handle,
	input  logic [KIND_BITS-1:0] kind,
	input  logic                wants_aux,
	output logic                q_valid,
	input  logic                q_pop,
	output gha_pkg::ctl_t       q_ctl,
	output logic [HW-1:0]       q_handle,
	output logic [KIND_BITS-1:0] q_kind
);
	import gha_pkg::*;

	ctl_t                 ctl_q    [2];
	logic [HW-1:0]        handle_q [2];
	logic [KIND_BITS-1:0] kind_q   [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	ctl_t                 ctl_in;
	logic                 push;

	// classify the command
	always_comb begin
		ctl_in.wants_aux = wants_aux;
		case (cmd)
			CMD_ALLOC:  ctl_in.op = OP_ALLOC;
			CMD_FREE:   ctl_in.op = OP_FREE;
			CMD_LOOKUP: ctl_in.op = OP_LOOKUP;
			default:    ctl_in.op = OP_BAD;
		endcase
	end

	assign req_ready = (count_q != 2'd2);
	assign push      = req_valid && req_ready;
	assign q_valid   = (count_q != 2'd0);
	assign q_ctl     = ctl_q[rd_ptr_q];
	assign q_handle  = handle_q[rd_ptr_q];
	assign q_kind    = kind_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ctl_q[wr_ptr_q]    <= ctl_in;
			handle_q[wr_ptr_q] <= handle;
			kind_q[wr_ptr_q]   <= kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/gha_back.sv =====
`timescale 1ns / 1ps

module gha_back #(
	parameter int SLOT_BITS = 10,
	parameter int GEN_BITS  = 16,
	parameter int AUX_SLOTS = 256,
	parameter int KIND_BITS = 16,
	localparam int HW    = GEN_BITS + SLOT_BITS,
	localparam int AUX_W = $clog2(AUX_SLOTS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  gha_pkg::ctl_t        q_ctl,
	input  logic [HW-1:0]        q_handle,
	input  logic [KIND_BITS-1:0] q_kind,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [2:0]           status,
	output logic [HW-1:0]        handle_out,
	output logic [KIND_BITS-1:0] kind_out,
	output logic [AUX_W-1:0]     aux_slot
);
	import gha_pkg::*;

	localparam int NSLOTS = 1 << SLOT_BITS;
	localparam int SL     = SLOT_BITS / 2;
	localparam int SH     = SLOT_BITS - SL;
	localparam int SCOLS  = 1 << SL;
	localparam int SROWS  = 1 << SH;
	localparam int AL     = AUX_W / 2;
	localparam int AH     = AUX_W - AL;
	localparam int ACOLS  = 1 << AL;
	localparam int AROWS  = 1 << AH;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_AUX_FIRST,
		S_AUX_NEXT,
		S_CHECK,
		S_FREE_AUX
	} state_t;

	function automatic logic [SL-1:0] pick_scol(input logic [SCOLS-1:0] v);
		logic [SL-1:0] r;
		r = '0;
		for (int i = SCOLS - 1; i >= 0; i--) if (v[i]) r = SL'(i);
		return r;
	endfunction

	function automatic logic [SH-1:0] pick_srow(input logic [SROWS-1:0] v);
		logic [SH-1:0] r;
		r = '0;
		for (int i = SROWS - 1; i >= 0; i--) if (v[i]) r = SH'(i);
		return r;
	endfunction

	function automatic logic [AL-1:0] pick_acol(input logic [ACOLS-1:0] v);
		logic [AL-1:0] r;
		r = '0;
		for (int i = ACOLS - 1; i >= 0; i--) if (v[i]) r = AL'(i);
		return r;
	endfunction

	function automatic logic [AH-1:0] pick_arow(input logic [AROWS-1:0] v);
		logic [AH-1:0] r;
		r = '0;
		for (int i = AROWS - 1; i >= 0; i--) if (v[i]) r = AH'(i);
		return r;
	endfunction

	// aux ids that may ever be granted in a row (never id zero)
	function automatic logic [ACOLS-1:0] aux_ok(input logic [AH-1:0] row);
		logic [ACOLS-1:0] m;
		for (int b = 0; b < ACOLS; b++)
			m[b] = ((int'(row) * ACOLS + b) != 0) && ((int'(row) * ACOLS + b) < AUX_SLOTS);
		return m;
	endfunction

	function automatic logic [ACOLS-1:0] ge_cmask(input logic [AL-1:0] sb);
		logic [ACOLS-1:0] m;
		for (int b = 0; b < ACOLS; b++) m[b] = (b >= int'(sb));
		return m;
	endfunction

	function automatic logic [AROWS-1:0] gt_rmask(input logic [AH-1:0] r);
		logic [AROWS-1:0] m;
		for (int i = 0; i < AROWS; i++) m[i] = (i > int'(r));
		return m;
	endfunction

	// memories
	logic [GEN_BITS-1:0]  slot_gen_mem  [NSLOTS];
	logic [KIND_BITS-1:0] slot_kind_mem [NSLOTS];
	logic [AUX_W-1:0]     slot_aux_mem  [NSLOTS];
	logic [SCOLS-1:0]     occ_mem       [SROWS];
	logic [ACOLS-1:0]     aux_mem       [AROWS];

	logic [GEN_BITS-1:0]  gen_rd_q;
	logic [KIND_BITS-1:0] kind_rd_q;
	logic [AUX_W-1:0]     saux_rd_q;
	logic [SCOLS-1:0]     occ_rd_q;
	logic [ACOLS-1:0]     aux_rd_q;
	logic [SH-1:0]        srow_q;
	logic [AH-1:0]        arow_q;

	// control state
	state_t               state_q;
	logic [SROWS-1:0]     occ_vld_q;
	logic [SROWS-1:0]     slot_nfull_q;
	logic [AROWS-1:0]     aux_vld_q;
	logic [AROWS-1:0]     aux_nfull_q;
	logic [GEN_BITS-1:0]  gen_q;
	logic [AUX_W-1:0]     aux_last_q;
	logic                 rsp_valid_q;

	// current item
	op_t                  op_q;
	logic                 wants_q;
	logic [GEN_BITS-1:0]  gen_in_q;
	logic [SLOT_BITS-1:0] idx_q;
	logic [KIND_BITS-1:0] kind_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic [HW-1:0]        hnew_q;
	logic [AUX_W-1:0]     auxid_q;
	logic [2:0]           status_q;
	logic [HW-1:0]        handle_out_q;
	logic [KIND_BITS-1:0] kind_out_q;
	logic [AUX_W-1:0]     aux_slot_q;

	// combinational next values
	state_t               state_d;
	logic                 res_ld;
	logic [2:0]           res_status;
	logic [HW-1:0]        res_handle;
	logic [KIND_BITS-1:0] res_kind;
	logic [AUX_W-1:0]     res_aux;
	logic [SH-1:0]        occ_raddr;
	logic                 occ_we;
	logic [SCOLS-1:0]     occ_wdata;
	logic                 occ_nfull_new;
	logic [AH-1:0]        aux_raddr;
	logic                 aux_we;
	logic [ACOLS-1:0]     aux_wdata;
	logic                 aux_nfull_new;
	logic                 aux_grant;
	logic [AUX_W-1:0]     grant_id;
	logic                 slot_we;
	logic [SLOT_BITS-1:0] slot_waddr;
	logic                 saux_we;
	logic [AUX_W-1:0]     saux_wdata;
	logic                 gen_adv;
	logic                 free_ld;
	logic [SCOLS-1:0]     occ_word;
	logic [ACOLS-1:0]     aux_word;
	logic [ACOLS-1:0]     aux_busy;
	logic [ACOLS-1:0]     aux_fwd;
	logic [AROWS-1:0]     row_cand;
	logic [SL-1:0]        scol;
	logic [AL-1:0]        acol;
	logic [GEN_BITS-1:0]  gen_inc;
	logic [GEN_BITS-1:0]  gen_next;
	logic                 out_free;
	logic                 hit;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign q_pop    = (state_q == S_IDLE) && q_valid && out_free;
	assign occ_word = occ_vld_q[srow_q] ? occ_rd_q : '0;
	assign aux_word = aux_vld_q[arow_q] ? aux_rd_q : '0;
	assign aux_busy = aux_word | ~aux_ok(arow_q);
	assign aux_fwd  = ~aux_busy & ge_cmask(aux_last_q[AL-1:0]);
	assign row_cand = aux_nfull_q & gt_rmask(arow_q);
	assign gen_inc  = gen_q + GEN_BITS'(1);
	assign gen_next = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
	assign hit      = occ_word[idx_q[SL-1:0]] && (gen_rd_q == gen_in_q) && (op_q != OP_BAD);

	always_comb begin
		state_d       = state_q;
		res_ld        = 1'b0;
		res_status    = ST_OK;
		res_handle    = '0;
		res_kind      = '0;
		res_aux       = '0;
		occ_raddr     = q_handle[SLOT_BITS-1:SL];
		occ_we        = 1'b0;
		occ_wdata     = occ_word;
		occ_nfull_new = 1'b1;
		aux_raddr     = aux_last_q[AUX_W-1:AL];
		aux_we        = 1'b0;
		aux_wdata     = aux_word;
		aux_nfull_new = 1'b1;
		aux_grant     = 1'b0;
		grant_id      = '0;
		slot_we       = 1'b0;
		slot_waddr    = slot_q;
		saux_we       = 1'b0;
		saux_wdata    = '0;
		gen_adv       = 1'b0;
		free_ld       = 1'b0;
		scol          = pick_scol(~occ_word);
		acol          = pick_acol(aux_fwd);
		case (state_q)
			S_IDLE: begin
				if (q_ctl.op == OP_ALLOC) occ_raddr = pick_srow(slot_nfull_q);
				if (q_pop) begin
					if (q_ctl.op == OP_ALLOC) begin
						if (slot_nfull_q == '0) begin
							res_ld     = 1'b1;
							res_status = ST_FULL;
						end else begin
							state_d = S_ALLOC;
						end
					end else begin
						state_d = S_CHECK;
					end
				end
			end
			S_ALLOC: begin
				slot_waddr    = {srow_q, scol};
				occ_we        = 1'b1;
				occ_wdata     = occ_word | (SCOLS'(1) << scol);
				occ_nfull_new = ~&occ_wdata;
				slot_we       = 1'b1;
				saux_we       = 1'b1;
				gen_adv       = 1'b1;
				if (wants_q) begin
					state_d = S_AUX_FIRST;
				end else begin
					res_ld     = 1'b1;
					res_handle = {gen_next, srow_q, scol};
					res_kind   = kind_q;
					state_d    = S_IDLE;
				end
			end
			S_AUX_FIRST: begin
				if (aux_fwd != '0) begin
					aux_grant = 1'b1;
				end else if (aux_nfull_q == '0) begin
					res_ld     = 1'b1;
					res_status = ST_AUX_EXH;
					res_handle = hnew_q;
					res_kind   = kind_q;
					state_d    = S_IDLE;
				end else begin
					aux_raddr = (row_cand != '0) ? pick_arow(row_cand) : pick_arow(aux_nfull_q);
					state_d   = S_AUX_NEXT;
				end
			end
			S_AUX_NEXT: begin
				acol      = pick_acol(~aux_busy);
				aux_grant = 1'b1;
			end
			S_CHECK: begin
				aux_raddr = saux_rd_q[AUX_W-1:AL];
				if (!hit) begin
					res_ld     = 1'b1;
					res_status = ST_STALE;
					state_d    = S_IDLE;
				end else if (op_q == OP_LOOKUP) begin
					res_ld     = 1'b1;
					res_handle = {gen_in_q, idx_q};
					res_kind   = kind_rd_q;
					res_aux    = saux_rd_q;
					state_d    = S_IDLE;
				end else begin
					occ_we    = 1'b1;
					occ_wdata = occ_word & ~(SCOLS'(1) << idx_q[SL-1:0]);
					if (saux_rd_q == '0) begin
						res_ld     = 1'b1;
						res_handle = {gen_in_q, idx_q};
						state_d    = S_IDLE;
					end else begin
						free_ld = 1'b1;
						state_d = S_FREE_AUX;
					end
				end
			end
			S_FREE_AUX: begin
				aux_we     = 1'b1;
				aux_wdata  = aux_word & ~(ACOLS'(1) << auxid_q[AL-1:0]);
				res_ld     = 1'b1;
				res_status = aux_word[auxid_q[AL-1:0]] ? ST_OK : ST_AUX_IDLE;
				res_handle = {gen_in_q, idx_q};
				res_aux    = auxid_q;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (aux_grant) begin
			grant_id      = {arow_q, acol};
			aux_we        = 1'b1;
			aux_wdata     = aux_word | (ACOLS'(1) << acol);
			aux_nfull_new = |(~aux_wdata & aux_ok(arow_q));
			saux_we       = 1'b1;
			saux_wdata    = grant_id;
			res_ld        = 1'b1;
			res_handle    = hnew_q;
			res_kind      = kind_q;
			res_aux       = grant_id;
			state_d       = S_IDLE;
		end
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_gen_mem[slot_waddr]  <= gen_next;
			slot_kind_mem[slot_waddr] <= kind_q;
		end
		if (saux_we) slot_aux_mem[slot_waddr] <= saux_wdata;
		if (occ_we) occ_mem[srow_q] <= occ_wdata;
		if (aux_we) aux_mem[arow_q] <= aux_wdata;
		gen_rd_q  <= slot_gen_mem[q_handle[SLOT_BITS-1:0]];
		kind_rd_q <= slot_kind_mem[q_handle[SLOT_BITS-1:0]];
		saux_rd_q <= slot_aux_mem[q_handle[SLOT_BITS-1:0]];
		occ_rd_q  <= occ_mem[occ_raddr];
		aux_rd_q  <= aux_mem[aux_raddr];
		srow_q    <= occ_raddr;
		arow_q    <= aux_raddr;
	end

	// item payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q     <= q_ctl.op;
			wants_q  <= q_ctl.wants_aux;
			gen_in_q <= q_handle[HW-1:SLOT_BITS];
			idx_q    <= q_handle[SLOT_BITS-1:0];
			kind_q   <= q_kind;
		end
		if (gen_adv) begin
			slot_q <= slot_waddr;
			hnew_q <= {gen_next, slot_waddr};
		end
		if (free_ld) auxid_q <= saux_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			occ_vld_q    <= '0;
			slot_nfull_q <= '1;
			aux_vld_q    <= '0;
			for (int r = 0; r < AROWS; r++) aux_nfull_q[r] <= |aux_ok(AH'(r));
			gen_q        <= '0;
			aux_last_q   <= '0;
			rsp_valid_q  <= 1'b0;
			status_q     <= ST_OK;
			handle_out_q <= '0;
			kind_out_q   <= '0;
			aux_slot_q   <= '0;
		end else begin
			state_q <= state_d;
			if (occ_we) begin
				occ_vld_q[srow_q]    <= 1'b1;
				slot_nfull_q[srow_q] <= occ_nfull_new;
			end
			if (aux_we) begin
				aux_vld_q[arow_q]   <= 1'b1;
				aux_nfull_q[arow_q] <= aux_nfull_new;
			end
			if (gen_adv) gen_q <= gen_next;
			if (aux_grant) aux_last_q <= grant_id;
			if (res_ld) begin
				rsp_valid_q  <= 1'b1;
				status_q     <= res_status;
				handle_out_q <= res_handle;
				kind_out_q   <= res_kind;
				aux_slot_q   <= res_aux;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign handle_out = handle_out_q;
	assign kind_out   = kind_out_q;
	assign aux_slot   = aux_slot_q;

	a_gen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC) |=> (gen_q != '0))
		else $error("generation is zero after allocate");

	a_row_has_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC) |-> !(&occ_word))
		else $error("summary chose a full slot row");

	a_aux_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		aux_grant |-> ((grant_id != '0) && !aux_word[acol]))
		else $error("aux grant of id zero or of a busy id");

	a_result_fits: assert property (@(posedge clk) disable iff (!arst_n)
		res_ld |-> out_free)
		else $error("result loaded over a pending response");

endmodule

// ===== test/generational_handle_allocator_tb.sv =====
`timescale 1ns / 1ps

module generational_handle_allocator_tb;
	import gha_pkg::*;

	localparam int SLOT_BITS = DEF_SLOT_BITS;
	localparam int GEN_BITS  = DEF_GEN_BITS;
	localparam int AUX_SLOTS = DEF_AUX_SLOTS;
	localparam int KIND_BITS = DEF_KIND_BITS;
	localparam int HW        = GEN_BITS + SLOT_BITS;
	localparam int AUX_W     = $clog2(AUX_SLOTS);
	localparam int NSLOTS    = 1 << SLOT_BITS;
	// code the block never defines; must read back as stale
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// cycles with no transfer on either side before the run is declared hung
	localparam int HANG_LIMIT = 4000;
	// long receiver hold-off, starts once this many requests went in
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER  = 500;

	typedef struct packed {
		logic [1:0]           cmd;
		logic [HW-1:0]        handle;
		logic [KIND_BITS-1:0] kind;
		logic                 wants_aux;
	} request_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [HW-1:0]        handle;
		logic [KIND_BITS-1:0] kind;
		logic [AUX_W-1:0]     aux;
	} response_t;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	logic [1:0]           cmd;
	logic [HW-1:0]        handle;
	logic [KIND_BITS-1:0] kind;
	logic                 wants_aux;
	logic                 rsp_valid;
	logic                 rsp_ready;
	logic [2:0]           status;
	logic [HW-1:0]        handle_out;
	logic [KIND_BITS-1:0] kind_out;
	logic [AUX_W-1:0]     aux_slot;

	generational_handle_allocator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.cmd        (cmd),
		.handle     (handle),
		.kind       (kind),
		.wants_aux  (wants_aux),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.handle_out (handle_out),
		.kind_out   (kind_out),
		.aux_slot   (aux_slot)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// shadow copy of the slot table and aux pool
	logic [HW-1:0]        tbl_handle [NSLOTS];
	logic [KIND_BITS-1:0] tbl_kind   [NSLOTS];
	logic [AUX_W-1:0]     tbl_aux    [NSLOTS];
	logic                 pool_busy  [AUX_SLOTS];
	logic [AUX_W-1:0]     pool_last;
	logic [GEN_BITS-1:0]  gen_ctr;

	// handles currently valid, and handles that were freed (stale on reuse)
	logic [HW-1:0] live_handles [$];
	logic [HW-1:0] dead_handles [$];

	// requests waiting for the driver, each with its predicted response
	request_t  pending_reqs [$];
	response_t pending_rsps [$];
	// responses owed by the block, oldest first
	response_t owed_rsps [$];

	int errors;
	int reqs_sent;

	task automatic report(input string what, input response_t got, input response_t want);
		errors++;
		$display("mismatch %s: got st=%0d h=%h k=%h a=%0d, want st=%0d h=%h k=%h a=%0d",
			what, got.status, got.handle, got.kind, got.aux,
			want.status, want.handle, want.kind, want.aux);
	endtask

	// rotating aux grant: resumes at the last grant, slot 0 never handed out
	function automatic logic [AUX_W-1:0] grant_aux();
		logic [AUX_W-1:0] id;
		for (int i = 0; i < AUX_SLOTS; i++) begin
			id = AUX_W'((int'(pool_last) + i) % AUX_SLOTS);
			if (id != 0 && !pool_busy[id]) begin
				pool_busy[id] = 1'b1;
				pool_last = id;
				return id;
			end
		end
		return '0;
	endfunction

	// applies one request to the shadow table and returns the response it owes
	function automatic response_t apply_request(input request_t rq);
		response_t rs;
		int s;
		logic [SLOT_BITS-1:0] idx;
		logic [AUX_W-1:0] a;
		rs = '0;
		idx = rq.handle[SLOT_BITS-1:0];
		if (rq.cmd == CMD_ALLOC) begin
			s = NSLOTS;
			for (int i = NSLOTS - 1; i >= 0; i--)
				if (tbl_handle[i] == '0) s = i;
			if (s == NSLOTS) begin
				rs.status = ST_FULL;
				return rs;
			end
			gen_ctr = gen_ctr + 1'b1;
			if (gen_ctr == '0) gen_ctr = GEN_BITS'(1);
			tbl_handle[s] = {gen_ctr, SLOT_BITS'(s)};
			tbl_kind[s] = rq.kind;
			tbl_aux[s] = '0;
			rs.status = ST_OK;
			rs.handle = tbl_handle[s];
			rs.kind = rq.kind;
			if (rq.wants_aux) begin
				tbl_aux[s] = grant_aux();
				if (tbl_aux[s] == '0) rs.status = ST_AUX_EXH;
			end
			rs.aux = tbl_aux[s];
			return rs;
		end
		if (rq.cmd == CMD_UNUSED || tbl_handle[idx] == '0 || tbl_handle[idx] != rq.handle) begin
			rs.status = ST_STALE;
			return rs;
		end
		rs.handle = rq.handle;
		if (rq.cmd == CMD_LOOKUP) begin
			rs.status = ST_OK;
			rs.kind = tbl_kind[idx];
			rs.aux = tbl_aux[idx];
			return rs;
		end
		a = tbl_aux[idx];
		rs.status = ST_OK;
		if (a != '0) begin
			if (!pool_busy[a]) rs.status = ST_AUX_IDLE;
			pool_busy[a] = 1'b0;
		end
		tbl_handle[idx] = '0;
		tbl_kind[idx] = '0;
		tbl_aux[idx] = '0;
		rs.aux = a;
		return rs;
	endfunction

	// predicts, queues for the driver and keeps the handle lists current
	task automatic queue_request(input logic [1:0] c, input logic [HW-1:0] h,
			input logic [KIND_BITS-1:0] k, input logic wa, output response_t rs);
		request_t rq;
		rq = '{cmd: c, handle: h, kind: k, wants_aux: wa};
		rs = apply_request(rq);
		pending_reqs.push_back(rq);
		pending_rsps.push_back(rs);
		if (c == CMD_ALLOC && rs.handle != '0)
			live_handles.push_back(rs.handle);
		if (c == CMD_FREE && rs.status != ST_STALE)
			for (int i = 0; i < live_handles.size(); i++)
				if (live_handles[i] == h) begin
					live_handles.delete(i);
					dead_handles.push_back(h);
					break;
				end
	endtask

	function automatic logic [HW-1:0] pick_live();
		if (live_handles.size() == 0) return HW'($urandom);
		return live_handles[$urandom_range(live_handles.size() - 1)];
	endfunction

	// a handle that must not match: random, retired, a live one with a bad generation, or zero
	function automatic logic [HW-1:0] pick_stale();
		logic [HW-1:0] h;
		case ($urandom_range(3))
			0: h = HW'($urandom);
			1: h = dead_handles.size() ? dead_handles[$urandom_range(dead_handles.size() - 1)]
				: HW'($urandom);
			2: h = pick_live() ^ (HW'($urandom_range(1, (1 << GEN_BITS) - 1)) << SLOT_BITS);
			default: h = '0;
		endcase
		return h;
	endfunction

	// one random command mixed from everything the block takes
	task automatic queue_mixed();
		response_t rs;
		int roll;
		roll = $urandom_range(99);
		if (roll < 35)
			queue_request(CMD_ALLOC, HW'($urandom), KIND_BITS'($urandom),
				1'($urandom_range(1)), rs);
		else if (roll < 55)
			queue_request(CMD_FREE, pick_live(), KIND_BITS'($urandom),
				1'($urandom_range(1)), rs);
		else if (roll < 80)
			queue_request(CMD_LOOKUP, pick_live(), KIND_BITS'($urandom),
				1'($urandom_range(1)), rs);
		else if (roll < 95)
			queue_request(roll[0] ? CMD_FREE : CMD_LOOKUP, pick_stale(),
				KIND_BITS'($urandom), 1'($urandom_range(1)), rs);
		else
			queue_request(CMD_UNUSED, HW'($urandom), KIND_BITS'($urandom),
				1'($urandom_range(1)), rs);
	endtask

	// driver: bursts of back to back requests separated by random gaps
	request_t  cur_req;
	response_t cur_rsp;
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid  <= 1'b0;
			cmd        <= CMD_ALLOC;
			handle     <= '0;
			kind       <= '0;
			wants_aux  <= 1'b0;
			burst_left <= 1;
			gap_left   <= 0;
		end else if (!(req_valid && !req_ready)) begin
			// the item on the port, if any, was transferred at this edge
			if (req_valid) begin
				owed_rsps.push_back(cur_rsp);
				reqs_sent++;
			end
			if (gap_left > 0) begin
				gap_left  <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				cur_req = pending_reqs.pop_front();
				cur_rsp = pending_rsps.pop_front();
				req_valid <= 1'b1;
				cmd       <= cur_req.cmd;
				handle    <= cur_req.handle;
				kind      <= cur_req.kind;
				wants_aux <= cur_req.wants_aux;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					// about a third of the bursts run straight into the next
					gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver: a free-running phase counter rerolls the stall pattern, plus one long hold-off
	int rx_phase;
	int rx_mode;
	int hold_left;
	bit held_once;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rx_phase  <= 0;
			rx_mode   <= 0;
			hold_left <= 0;
			held_once <= 1'b0;
		end else begin
			rx_phase <= rx_phase + 1;
			if (rx_phase % 64 == 63) rx_mode <= $urandom_range(3);
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp_ready <= 1'b0;
			end else if (!held_once && reqs_sent >= HOLD_AFTER) begin
				// the block fills up and must push back on the request side
				held_once <= 1'b1;
				hold_left <= HOLD_CYCLES;
				rsp_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= 1'($urandom_range(1));
					2: rsp_ready <= ($urandom_range(3) == 0);
					default: rsp_ready <= (rx_phase % 8) < 5;
				endcase
			end
		end
	end

	// monitor: each response transfer against the oldest owed response
	response_t got_rsp;
	response_t want_rsp;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			got_rsp = '{status: status, handle: handle_out, kind: kind_out, aux: aux_slot};
			if (owed_rsps.size() == 0) begin
				report("unexpected response", got_rsp, '0);
			end else begin
				want_rsp = owed_rsps.pop_front();
				if (got_rsp.status != want_rsp.status) report("status", got_rsp, want_rsp);
				if (got_rsp.handle != want_rsp.handle) report("handle_out", got_rsp, want_rsp);
				if (got_rsp.kind != want_rsp.kind) report("kind_out", got_rsp, want_rsp);
				if (got_rsp.aux != want_rsp.aux) report("aux_slot", got_rsp, want_rsp);
			end
		end
	end

	// watchdog: any transfer on either side resets the count
	int idle_cycles;

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("timeout waiting for a transfer");
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		response_t rs;
		logic [HW-1:0] h_plain;
		logic [HW-1:0] h_aux;
		int full_seen;

		errors = 0;
		reqs_sent = 0;
		idle_cycles = 0;
		for (int i = 0; i < NSLOTS; i++) begin
			tbl_handle[i] = '0;
			tbl_kind[i] = '0;
			tbl_aux[i] = '0;
		end
		for (int i = 0; i < AUX_SLOTS; i++) pool_busy[i] = 1'b0;
		pool_last = '0;
		gen_ctr = '0;

		// directed: kind extremes, aux on and off, lookups, frees, stale cases
		queue_request(CMD_ALLOC, '0, '0, 1'b0, rs);
		h_plain = rs.handle;
		queue_request(CMD_ALLOC, '1, '1, 1'b1, rs);
		h_aux = rs.handle;
		queue_request(CMD_LOOKUP, h_plain, '1, 1'b1, rs);
		queue_request(CMD_LOOKUP, h_aux, '0, 1'b0, rs);
		queue_request(CMD_LOOKUP, '0, '0, 1'b0, rs);
		queue_request(CMD_FREE, '0, '0, 1'b0, rs);
		queue_request(CMD_LOOKUP, '1, '1, 1'b1, rs);
		queue_request(CMD_UNUSED, h_plain, '1, 1'b1, rs);
		queue_request(CMD_UNUSED, '0, '0, 1'b0, rs);
		// right slot, wrong generation
		queue_request(CMD_LOOKUP, h_aux ^ (HW'(1) << SLOT_BITS), '0, 1'b0, rs);
		queue_request(CMD_FREE, h_aux, '0, 1'b0, rs);
		queue_request(CMD_FREE, h_aux, '0, 1'b0, rs);
		queue_request(CMD_LOOKUP, h_aux, '0, 1'b0, rs);
		queue_request(CMD_ALLOC, '0, 16'h5a5a, 1'b1, rs);
		queue_request(CMD_ALLOC, '1, 16'ha5a5, 1'b1, rs);
		queue_request(CMD_FREE, h_plain, '1, 1'b1, rs);
		queue_request(CMD_LOOKUP, h_plain, '0, 1'b0, rs);
		queue_request(CMD_ALLOC, '0, 16'h0001, 1'b0, rs);

		// random mix of live and stale traffic
		for (int i = 0; i < 100; i++) queue_mixed();

		// fill the table, mostly with aux, until the aux pool and the table run dry
		full_seen = 0;
		while (full_seen < 6) begin
			if ($urandom_range(9) == 0)
				queue_request(CMD_LOOKUP, pick_live(), KIND_BITS'($urandom),
					1'($urandom_range(1)), rs);
			else begin
				queue_request(CMD_ALLOC, HW'($urandom), KIND_BITS'($urandom),
					$urandom_range(9) != 0, rs);
				if (rs.status == ST_FULL) full_seen++;
			end
		end

		// drain part of it with lookups and stale probes mixed in
		for (int i = 0; i < 260; i++) begin
			if ($urandom_range(4) == 0)
				queue_request(CMD_LOOKUP, $urandom_range(1) ? pick_live() : pick_stale(),
					KIND_BITS'($urandom), 1'($urandom_range(1)), rs);
			else
				queue_request(CMD_FREE, pick_live(), KIND_BITS'($urandom),
					1'($urandom_range(1)), rs);
		end

		for (int i = 0; i < 60; i++) queue_mixed();

		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// everything sent and every response in
		while (pending_reqs.size() != 0 || req_valid || owed_rsps.size() != 0)
			@(posedge clk);
		// catch any response the block adds after the last one owed
		repeat (20) @(posedge clk);

		if (errors == 0 && owed_rsps.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== generational_handle_allocator.f =====
rtl/gha_pkg.sv
rtl/gha_front.sv
rtl/gha_back.sv
rtl/generational_handle_allocator.sv
test/generational_handle_allocator_tb.sv
